@@ rtl/sre_pkg.sv @@
package sre_pkg;

    // Input and result field widths
    localparam int LEN_W   = 24;
    localparam int ANGLE_W = 9;
    localparam int MEAN_W  = 16;
    localparam int ROT_W   = 7;

    // Histogram geometry and angle constants
    localparam int BIN_COUNT    = 180;
    localparam int BIN_W        = 8;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int WINDOW_STEP  = 5;
    localparam int WINDOW_LIMIT = 45;
    localparam int WIN_W        = 6;

    // Accumulator widths
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 17;
    localparam int CNT_MAX    = 131071;
    localparam int CLASS_CNT_W = 25;
    localparam int ACC_W      = 32;
    localparam int PROD_W     = 27;

    // Shared divider widths
    localparam int DIV_N_W   = 40;
    localparam int DIV_D_W   = 25;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/sre_ram.sv @@
module sre_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 180
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/sre_divider.sv @@
module sre_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  sre_pkg::div_req_t req,
    output sre_pkg::div_rsp_t rsp
);
    import sre_pkg::*;

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            rem_next = fits ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/segment_rotation_estimator.sv @@
// Each item not marked last is accepted with the histogram read, then written back (ST_UPD).
// The last item then runs the mean divide (ST_MDIV), one to eight window scans of the 180 bins,
// each followed by a drain (ST_SCAN, ST_DRAIN), the offset divide (ST_RDIV, when a segment
// qualified) and the load (ST_OUT); the load waits while the output register is full.
// aresetn (synchronous, active low) clears the sequencer, the bin valid bits, the length sum
// and count and the output valid flag; histogram entries read as zero until written.
module segment_rotation_estimator #(
    parameter int MAX_SEGMENTS     = 65536,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sre_pkg::LEN_W-1:0]   s_segment_length,
    input  logic signed [sre_pkg::ANGLE_W-1:0] s_segment_angle,
    input  logic                        s_last_segment,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sre_pkg::MEAN_W-1:0]  m_mean_length,
    output logic signed [sre_pkg::ROT_W-1:0] m_rotation_deg
);
    import sre_pkg::*;

    localparam logic [CNT_W-1:0] COUNT_LIMIT =
        CNT_W'((MAX_SEGMENTS > CNT_MAX) ? CNT_MAX : MAX_SEGMENTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_MDIV  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_RDIV  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Fold any 9-bit angle into bins 0..179
    function automatic logic [BIN_W-1:0] fold_angle(input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W:0] t;
        t = $signed({a[ANGLE_W-1], a}) + (ANGLE_W+1)'(HALF_TURN);
        if (t < 0) begin
            t = t + (ANGLE_W+1)'(HALF_TURN);
        end else if (t >= (ANGLE_W+1)'(2 * HALF_TURN)) begin
            t = t - (ANGLE_W+1)'(2 * HALF_TURN);
        end else if (t >= (ANGLE_W+1)'(HALF_TURN)) begin
            t = t - (ANGLE_W+1)'(HALF_TURN);
        end
        return t[BIN_W-1:0];
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [SUM_W-1:0]        length_sum_reg, length_sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [BIN_COUNT-1:0]    hist_vld_reg, hist_vld_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic                    last_reg, last_next;
    logic                    vbit_reg;
    logic [MEAN_W-1:0]       mean_reg, mean_next;
    logic [WIN_W-1:0]        window_reg, window_next;
    logic [BIN_W-1:0]        scan_addr_reg, scan_addr_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [BIN_W-1:0]        rd_bin_reg;
    logic                    p_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [CNT_W-1:0]        n_reg;
    logic                    h_reg, v_reg;
    logic signed [ACC_W-1:0] hsum_reg, hsum_next, vsum_reg, vsum_next;
    logic [CLASS_CNT_W-1:0]  hcnt_reg, hcnt_next, vcnt_reg, vcnt_next;
    logic                    neg_reg, neg_next;
    logic [ROT_W-1:0]        rot_reg, rot_next;
    logic                    m_valid_reg, m_valid_next;
    logic [MEAN_W-1:0]       m_mean_reg, m_mean_next;
    logic [ROT_W-1:0]        m_rot_reg, m_rot_next;

    logic [BIN_W-1:0]        ram_raddr;
    logic [CNT_W-1:0]        ram_rdata;
    logic                    ram_we;
    logic [CNT_W-1:0]        bin_val;
    logic [CNT_W-1:0]        bin_inc;
    logic                    accept;
    logic [SUM_W:0]          sum_wide;
    logic [DIV_N_W-1:0]      mean_shift;
    logic [CNT_W-1:0]        n_now;
    logic                    h_now, v_now;
    logic signed [ANGLE_W-1:0] off_now;
    logic [ANGLE_W-1:0]      b_ext, w_ext;
    logic signed [ACC_W-1:0] sel_sum;
    logic [CLASS_CNT_W-1:0]  sel_cnt;
    logic [ACC_W-1:0]        sel_mag;
    logic [ROT_W-1:0]        rot_mag;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Histogram store, one read-modify-write per item
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_addr_reg : fold_angle(s_segment_angle);
    assign ram_we    = (state_reg == ST_UPD);
    assign bin_val   = vbit_reg ? ram_rdata : '0;
    assign bin_inc   = (bin_val < COUNT_LIMIT) ? bin_val + CNT_W'(1) : bin_val;

    sre_ram #(
        .WIDTH(CNT_W),
        .DEPTH(BIN_COUNT)
    ) u_hist (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(bin_reg),
        .wdata(bin_inc),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sre_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Saturating length sum
    assign sum_wide   = {1'b0, length_sum_reg} + (SUM_W+1)'(s_segment_length);
    assign mean_shift = div_rsp.quotient >> LENGTH_FRAC_BITS;

    // Classify the bin just read against the current window
    assign b_ext = ANGLE_W'(rd_bin_reg);
    assign w_ext = ANGLE_W'(window_reg);
    assign n_now = bin_val;
    always_comb begin
        h_now = (b_ext < w_ext) || (b_ext > ANGLE_W'(HALF_TURN) - w_ext);
        v_now = !h_now && (b_ext > ANGLE_W'(QUARTER_TURN) - w_ext)
                       && (b_ext < ANGLE_W'(QUARTER_TURN) + w_ext);
        if (h_now) begin
            off_now = (b_ext < ANGLE_W'(QUARTER_TURN)) ? $signed(b_ext)
                                                       : $signed(b_ext - ANGLE_W'(HALF_TURN));
        end else begin
            off_now = $signed(b_ext - ANGLE_W'(QUARTER_TURN));
        end
    end

    // Pick the larger class, horizontal on a tie
    assign sel_sum = (vcnt_reg > hcnt_reg) ? vsum_reg : hsum_reg;
    assign sel_cnt = (vcnt_reg > hcnt_reg) ? vcnt_reg : hcnt_reg;
    assign sel_mag = sel_sum[ACC_W-1] ? ACC_W'(-sel_sum) : ACC_W'(sel_sum);
    assign rot_mag = div_rsp.quotient[ROT_W-1:0];

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        length_sum_next = length_sum_reg;
        count_next      = count_reg;
        hist_vld_next   = hist_vld_reg;
        bin_next        = bin_reg;
        last_next       = last_reg;
        mean_next       = mean_reg;
        window_next     = window_reg;
        scan_addr_next  = scan_addr_reg;
        rd_vld_next     = 1'b0;
        hsum_next       = hsum_reg;
        vsum_next       = vsum_reg;
        hcnt_next       = hcnt_reg;
        vcnt_next       = vcnt_reg;
        neg_next        = neg_reg;
        rot_next        = rot_reg;
        m_valid_next    = m_valid_reg;
        m_mean_next     = m_mean_reg;
        m_rot_next      = m_rot_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_N_W'(length_sum_reg);
        div_req.divisor  = DIV_D_W'(count_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Accumulate the registered products of the scan
        if (p_vld_reg && h_reg) begin
            hsum_next = hsum_reg + ACC_W'(prod_reg);
            hcnt_next = hcnt_reg + CLASS_CNT_W'(n_reg);
        end
        if (p_vld_reg && v_reg) begin
            vsum_next = vsum_reg + ACC_W'(prod_reg);
            vcnt_next = vcnt_reg + CLASS_CNT_W'(n_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    length_sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
                    count_next = (count_reg < COUNT_LIMIT) ? count_reg + CNT_W'(1)
                                                           : count_reg;
                    bin_next   = fold_angle(s_segment_angle);
                    last_next  = s_last_segment;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                hist_vld_next[bin_reg] = 1'b1;
                if (last_reg) begin
                    div_req.start = 1'b1;
                    state_next    = ST_MDIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MDIV: begin
                if (div_rsp.done) begin
                    if (count_reg == '0) begin
                        mean_next = '0;
                    end else if (|mean_shift[DIV_N_W-1:MEAN_W]) begin
                        mean_next = {MEAN_W{1'b1}};
                    end else begin
                        mean_next = mean_shift[MEAN_W-1:0];
                    end
                    window_next    = WIN_W'(WINDOW_STEP);
                    scan_addr_next = '0;
                    hsum_next      = '0;
                    vsum_next      = '0;
                    hcnt_next      = '0;
                    vcnt_next      = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_vld_next    = 1'b1;
                scan_addr_next = scan_addr_reg + BIN_W'(1);
                if (scan_addr_reg == BIN_W'(BIN_COUNT - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !p_vld_reg) begin
                    if (hcnt_reg != '0 || vcnt_reg != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_N_W'(sel_mag);
                        div_req.divisor  = DIV_D_W'(sel_cnt);
                        neg_next         = sel_sum[ACC_W-1];
                        state_next       = ST_RDIV;
                    end else if (window_reg + WIN_W'(WINDOW_STEP) >= WIN_W'(WINDOW_LIMIT)) begin
                        rot_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        window_next    = window_reg + WIN_W'(WINDOW_STEP);
                        scan_addr_next = '0;
                        hsum_next      = '0;
                        vsum_next      = '0;
                        hcnt_next      = '0;
                        vcnt_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_RDIV: begin
                if (div_rsp.done) begin
                    rot_next   = neg_reg ? (~rot_mag + ROT_W'(1)) : rot_mag;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load the result once the output register is free, then clear the set
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_mean_next     = mean_reg;
                    m_rot_next      = rot_reg;
                    hist_vld_next   = '0;
                    length_sum_next = '0;
                    count_next      = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            length_sum_reg <= '0;
            count_reg      <= '0;
            hist_vld_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            p_vld_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            length_sum_reg <= length_sum_next;
            count_reg      <= count_next;
            hist_vld_reg   <= hist_vld_next;
            rd_vld_reg     <= rd_vld_next;
            p_vld_reg      <= rd_vld_reg;
            m_valid_reg    <= m_valid_next;
        end
        bin_reg       <= bin_next;
        last_reg      <= last_next;
        vbit_reg      <= hist_vld_reg[ram_raddr];
        mean_reg      <= mean_next;
        window_reg    <= window_next;
        scan_addr_reg <= scan_addr_next;
        rd_bin_reg    <= scan_addr_reg;
        prod_reg      <= PROD_W'(off_now) * $signed(PROD_W'({1'b0, n_now}));
        n_reg         <= n_now;
        h_reg         <= h_now;
        v_reg         <= v_now;
        hsum_reg      <= hsum_next;
        vsum_reg      <= vsum_next;
        hcnt_reg      <= hcnt_next;
        vcnt_reg      <= vcnt_next;
        neg_reg       <= neg_next;
        rot_reg       <= rot_next;
        m_mean_reg    <= m_mean_next;
        m_rot_reg     <= m_rot_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_mean_length  = m_mean_reg;
    assign m_rotation_deg = $signed(m_rot_reg);

    // Checks
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_rot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_rotation_deg <= 7'sd39) && (m_rotation_deg >= -7'sd39)))
        else $error("rotation out of range");

    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_segment) |=> !s_ready)
        else $error("input taken during result computation");

    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!rd_vld_reg && !p_vld_reg && !div_rsp.busy))
        else $error("input ready while scan or divide active");

endmodule

@@ bench/segment_estimate_checker.sv @@
module segment_estimate_checker #(
    parameter int MAX_SEGMENTS     = 65536,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [sre_pkg::LEN_W-1:0]           s_segment_length,
    input  logic signed [sre_pkg::ANGLE_W-1:0]  s_segment_angle,
    input  logic                                s_last_segment,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [sre_pkg::MEAN_W-1:0]          m_mean_length,
    input  logic signed [sre_pkg::ROT_W-1:0]    m_rotation_deg,
    output int                                  pending_estimates,
    output int                                  failure_count,
    output int                                  results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import sre_pkg::*;

    // Counters stop at the parameter or at the 17-bit limit, whichever is lower
    localparam int SEG_LIMIT = (MAX_SEGMENTS < CNT_MAX) ? MAX_SEGMENTS : CNT_MAX;

    typedef struct {
        logic [MEAN_W-1:0]        mean_length;
        logic signed [ROT_W-1:0]  rotation_deg;
    } skew_estimate_t;

    // Shadow copy of the block's accumulators
    int                bin_tally [BIN_COUNT];
    logic [SUM_W-1:0]  len_total;
    int                seg_total;
    skew_estimate_t    estimate_queue [$];
    int                mismatch_total = 0;
    int                compared_total = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_total++;
    endtask

    task automatic clear_state();
        foreach (bin_tally[i]) bin_tally[i] = 0;
        len_total = '0;
        seg_total = 0;
    endtask

    // Fold any 9-bit pattern onto bins 0..179 with a non-negative modulo
    function automatic int fold_to_bin(input logic signed [ANGLE_W-1:0] angle);
        int folded;
        folded = (int'(angle) + HALF_TURN) % HALF_TURN;
        if (folded < 0) folded += HALF_TURN;
        return folded;
    endfunction

    // Widen the window around horizontal and vertical until a class is populated
    function automatic logic signed [ROT_W-1:0] skew_from_histogram();
        longint h_sum, v_sum, h_cnt, v_cnt;
        int offset;
        logic signed [ROT_W-1:0] skew;
        for (int w = WINDOW_STEP; w < WINDOW_LIMIT; w += WINDOW_STEP) begin
            h_sum = 0;
            v_sum = 0;
            h_cnt = 0;
            v_cnt = 0;
            for (int b = 0; b < BIN_COUNT; b++) begin
                if (bin_tally[b] == 0) continue;
                if (b < w || b > HALF_TURN - w) begin
                    offset = (b < QUARTER_TURN) ? b : b - HALF_TURN;
                    h_sum += longint'(offset) * bin_tally[b];
                    h_cnt += bin_tally[b];
                end else if (b > QUARTER_TURN - w && b < QUARTER_TURN + w) begin
                    v_sum += longint'(b - QUARTER_TURN) * bin_tally[b];
                    v_cnt += bin_tally[b];
                end
            end
            if (v_cnt > 0 || h_cnt > 0) begin
                // horizontal wins a tie; division truncates toward zero
                if (v_cnt > h_cnt) skew = ROT_W'(v_sum / v_cnt);
                else skew = ROT_W'(h_sum / h_cnt);
                return skew;
            end
        end
        return '0;
    endfunction

    // Accumulate one segment; on the closing segment queue the estimate and clear
    task automatic absorb_segment(input logic [LEN_W-1:0] len,
                                  input logic signed [ANGLE_W-1:0] angle,
                                  input logic closes_set);
        logic [SUM_W:0]   widened;
        logic [SUM_W-1:0] quotient;
        int               slot;
        skew_estimate_t   est;
        widened = {1'b0, len_total} + (SUM_W+1)'(len);
        len_total = widened[SUM_W] ? '1 : widened[SUM_W-1:0];
        if (seg_total < SEG_LIMIT) seg_total++;
        slot = fold_to_bin(angle);
        if (bin_tally[slot] < SEG_LIMIT) bin_tally[slot]++;
        if (closes_set) begin
            quotient = '0;
            if (seg_total > 0) quotient = (len_total / SUM_W'(seg_total)) >> LENGTH_FRAC_BITS;
            est.mean_length  = (quotient > 'hFFFF) ? '1 : quotient[MEAN_W-1:0];
            est.rotation_deg = skew_from_histogram();
            estimate_queue.push_back(est);
            clear_state();
        end
    endtask

    // Compare one delivered result with the oldest queued estimate
    task automatic check_result();
        skew_estimate_t exp_est;
        if (estimate_queue.size() == 0) begin
            report_mismatch($sformatf("result with no estimate pending: mean %0d rotation %0d",
                                      m_mean_length, m_rotation_deg));
            return;
        end
        exp_est = estimate_queue.pop_front();
        compared_total++;
        if (m_mean_length !== exp_est.mean_length)
            report_mismatch($sformatf("result %0d mean_length got %0d expected %0d",
                                      compared_total, m_mean_length, exp_est.mean_length));
        if (m_rotation_deg !== exp_est.rotation_deg)
            report_mismatch($sformatf("result %0d rotation_deg got %0d expected %0d",
                                      compared_total, m_rotation_deg, exp_est.rotation_deg));
    endtask

    // Watch both channels; check results before absorbing a closing segment
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            estimate_queue.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) absorb_segment(s_segment_length, s_segment_angle,
                                                   s_last_segment);
        end
        pending_estimates <= estimate_queue.size();
        failure_count     <= mismatch_total;
        results_checked   <= compared_total;
    end

endmodule

@@ bench/segment_rotation_estimator_test.sv @@
module segment_rotation_estimator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sre_pkg::*;

    localparam int MAX_SEGMENTS     = 65536;
    localparam int LENGTH_FRAC_BITS = 8;
    localparam int RANDOM_ITEMS     = 1600;
    localparam int HOLD_CYCLES      = 4000;
    localparam int SETTLE_CYCLES    = 1600;
    localparam int DRAIN_LIMIT      = 100000;
    localparam longint TIMEOUT_NS   = 64'd50_000_000;

    typedef enum int {
        ANG_NOISE, ANG_NEAR_H, ANG_NEAR_V, ANG_MIXED, ANG_GAP, ANG_UNIFORM
    } angle_mix_t;

    typedef enum int {
        LEN_FULL, LEN_SHORT, LEN_EXTREME, LEN_LONG, LEN_MIXED
    } length_mix_t;

    typedef enum int {
        READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC, READY_BLOCKED
    } ready_mix_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [LEN_W-1:0]          s_segment_length = '0;
    logic signed [ANGLE_W-1:0] s_segment_angle = '0;
    logic                      s_last_segment = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [MEAN_W-1:0]         m_mean_length;
    logic signed [ROT_W-1:0]   m_rotation_deg;
    int                        pending_estimates;
    int                        failure_count;
    int                        results_checked;

    bit hold_request = 1'b0;
    int burst_left   = 1;
    int segments_sent = 0;
    int sets_sent     = 0;

    segment_rotation_estimator #(
        .MAX_SEGMENTS    (MAX_SEGMENTS),
        .LENGTH_FRAC_BITS(LENGTH_FRAC_BITS)
    ) i_dut (.*);

    segment_estimate_checker #(
        .MAX_SEGMENTS    (MAX_SEGMENTS),
        .LENGTH_FRAC_BITS(LENGTH_FRAC_BITS)
    ) i_checker (.*);

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard stop for a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Offer one item, wait for acceptance, then maybe end the burst with a gap
    task automatic offer_segment(input logic [LEN_W-1:0] len,
                                 input logic signed [ANGLE_W-1:0] angle,
                                 input logic closes_set);
        int gap;
        s_valid          <= 1'b1;
        s_segment_length <= len;
        s_segment_angle  <= angle;
        s_last_segment   <= closes_set;
        do @(posedge aclk); while (!s_ready);
        segments_sent++;
        if (closes_set) sets_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Hold the sender until every queued estimate has been delivered
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_estimates != 0);
    endtask

    function automatic logic signed [ANGLE_W-1:0] pick_angle(input angle_mix_t mix);
        int a;
        int spread;
        int pick;
        spread = $urandom_range(0, 80);
        pick   = $urandom_range(0, 3);
        case (mix)
            ANG_NOISE: begin
                a = $urandom_range(0, 511);
            end
            ANG_NEAR_H: begin
                a = (pick == 0) ? 0 : ((pick == 1) ? 180 : -180);
                a = a + spread - 40;
            end
            ANG_NEAR_V: begin
                a = (pick[0]) ? 90 : -90;
                a = a + spread - 40;
            end
            ANG_MIXED: begin
                a = (pick == 0) ? 0 : ((pick == 1) ? 180 : ((pick == 2) ? 90 : -90));
                a = a + (spread % 25) - 12;
            end
            ANG_GAP: begin
                // angles that fold between the widest windows
                a = 40 + (spread % 11);
                case (pick)
                    1: a = 180 - a;
                    2: a = -a;
                    3: a = a - 180;
                    default: ;
                endcase
            end
            default: begin
                a = $urandom_range(0, 360);
                a = a - 180;
            end
        endcase
        return a[ANGLE_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] pick_length(input length_mix_t mix);
        length_mix_t m;
        m = (mix == LEN_MIXED) ? length_mix_t'($urandom_range(0, 3)) : mix;
        case (m)
            LEN_SHORT:   return LEN_W'($urandom_range(0, 4095));
            LEN_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            LEN_LONG:    return LEN_W'($urandom_range(24'hF00000, 24'hFFFFFF));
            default:     return LEN_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // Receiver: stretches of stall patterns, plus one long hold-off on request
    initial begin : ready_pattern
        ready_mix_t mix;
        int stretch;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mix     = ready_mix_t'($urandom_range(0, 4));
                stretch = $urandom_range(1, 60);
                for (int c = 0; c < stretch; c++) begin
                    case (mix)
                        READY_ALWAYS:   m_ready <= 1'b1;
                        READY_COIN:     m_ready <= ($urandom_range(0, 1) != 0);
                        READY_SPARSE:   m_ready <= ($urandom_range(0, 5) == 0);
                        READY_PERIODIC: m_ready <= (c % 3 == 0);
                        default:        m_ready <= 1'b0;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        angle_mix_t  amix;
        length_mix_t lmix;
        int set_size;
        int random_items;
        int random_sets;
        int wait_cycles;
        int leftover;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Lone segments: zero and full length, both ends of the angle range
        offer_segment(24'h000000, ANGLE_W'(0), 1'b1);
        offer_segment(24'hFFFFFF, ANGLE_W'(180), 1'b1);
        offer_segment(24'h000100, ANGLE_W'(-180), 1'b1);
        // Both vertical directions land in the same bin
        offer_segment(24'h0A0080, ANGLE_W'(90), 1'b0);
        offer_segment(24'h000001, ANGLE_W'(-90), 1'b1);
        // Negative horizontal mean truncates toward zero
        offer_segment(24'h001234, ANGLE_W'(-3), 1'b0);
        offer_segment(24'h00FF00, ANGLE_W'(-4), 1'b1);
        // Nothing inside any window
        offer_segment(24'h123456, ANGLE_W'(45), 1'b0);
        offer_segment(24'h7FFFFF, ANGLE_W'(135), 1'b0);
        offer_segment(24'h800000, ANGLE_W'(-45), 1'b1);
        // Tie between classes goes to horizontal
        offer_segment(24'h000300, ANGLE_W'(2), 1'b0);
        offer_segment(24'h000500, ANGLE_W'(93), 1'b1);
        // Vertical class larger
        offer_segment(24'h010000, ANGLE_W'(88), 1'b0);
        offer_segment(24'h020000, ANGLE_W'(87), 1'b0);
        offer_segment(24'h030000, ANGLE_W'(3), 1'b1);
        // Only the widest window catches these
        offer_segment(24'hFFFFFF, ANGLE_W'(39), 1'b0);
        offer_segment(24'hFFFFFF, ANGLE_W'(38), 1'b0);
        offer_segment(24'hFFFFFF, ANGLE_W'(-37), 1'b1);
        // Patterns outside -180..180
        offer_segment(24'h0000FF, ANGLE_W'(255), 1'b0);
        offer_segment(24'h000F00, ANGLE_W'(-256), 1'b1);
        // Just below horizontal
        offer_segment(24'h0000AA, ANGLE_W'(-1), 1'b1);
        drain_results();

        // Random sets with shaped angle and length mixes
        random_items = 0;
        random_sets  = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_sets == 10) hold_request = 1'b1;
            if (random_sets % 20 == 19) drain_results();
            amix = angle_mix_t'($urandom_range(0, 5));
            lmix = length_mix_t'($urandom_range(0, 4));
            if ($urandom_range(0, 11) == 0) set_size = $urandom_range(100, 300);
            else if ($urandom_range(0, 7) == 0) set_size = 1;
            else set_size = $urandom_range(2, 24);
            for (int i = 0; i < set_size; i++)
                offer_segment(pick_length(lmix), pick_angle(amix), i == set_size - 1);
            random_items += set_size;
            random_sets++;
        end

        // Drain, then let any stray result show up
        s_valid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge aclk);
            wait_cycles++;
        end while (pending_estimates != 0 && wait_cycles < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        leftover = pending_estimates;
        if (leftover != 0) $display("ERROR: %0d estimates never delivered", leftover);

        $display("Sent %0d segments in %0d sets; %0d estimates compared.",
                 segments_sent, sets_sent, results_checked);
        $display("Included fold, window, tie and extreme-length sets, a long output stall and drains.");
        if (failure_count == 0 && leftover == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
